### hw/rtl/tbr_pkg.sv
// ----------------------------------------------------------------------------
// tbr_pkg: touch button repeat shared definitions
// Event codes, register indexes, calibration constants and the button
// rectangle layout used by the interfaces and the top level.
// ----------------------------------------------------------------------------
package tbr_pkg;

	// Event codes
	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_PLUS  = 3'd1;
	localparam logic [2:0] EV_MINUS = 3'd2;
	localparam logic [2:0] EV_OK    = 3'd3;
	localparam logic [2:0] EV_BACK  = 3'd4;

	// Register indexes
	localparam logic [2:0] REG_STRIP_X    = 3'd0;
	localparam logic [2:0] REG_PLUS_RECT  = 3'd1;
	localparam logic [2:0] REG_MINUS_RECT = 3'd2;
	localparam logic [2:0] REG_OK_RECT    = 3'd3;
	localparam logic [2:0] REG_BACK_RECT  = 3'd4;
	localparam logic [2:0] REG_DELAY      = 3'd5;
	localparam logic [2:0] REG_RATE       = 3'd6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 34;

	// Reset values of the registers
	localparam logic [8:0]  STRIP_X_RST = 9'd240;
	localparam logic [15:0] DELAY_RST   = 16'd450;
	localparam logic [15:0] RATE_RST    = 16'd140;

	// Touch converter calibration
	localparam int RAW_X_MIN    = 340;
	localparam int RAW_X_MAX    = 3800;
	localparam int RAW_Y_MIN    = 240;
	localparam int RAW_Y_MAX    = 3850;
	localparam int SCREEN_X_MAX = 319;
	localparam int SCREEN_Y_MAX = 239;

	// Scaling is (v - lo) * top / span done as one multiply by a rounded-up
	// reciprocal. With a <= span < 2^12, a * span < 2^24, so a shift of 24
	// keeps the quotient exact.
	localparam int  SCALE_SH = 24;
	localparam int  X_SPAN   = RAW_X_MAX - RAW_X_MIN;
	localparam int  Y_SPAN   = RAW_Y_MAX - RAW_Y_MIN;
	localparam longint X_RECIP_L = (X_SPAN > 0) ?
		((longint'(SCREEN_X_MAX) << SCALE_SH) + longint'(X_SPAN) - 1) / longint'(X_SPAN)
		: 64'sd0;
	localparam longint Y_RECIP_L = (Y_SPAN > 0) ?
		((longint'(SCREEN_Y_MAX) << SCALE_SH) + longint'(Y_SPAN) - 1) / longint'(Y_SPAN)
		: 64'sd0;
	localparam logic [33:0] X_RECIP = 34'(X_RECIP_L);
	localparam logic [33:0] Y_RECIP = 34'(Y_RECIP_L);
	localparam logic [11:0] RAW_X_LO = 12'(RAW_X_MIN);
	localparam logic [11:0] RAW_X_HI = 12'(RAW_X_MAX);
	localparam logic [11:0] RAW_Y_LO = 12'(RAW_Y_MIN);
	localparam logic [11:0] RAW_Y_HI = 12'(RAW_Y_MAX);

	// Button rectangle, packed from the high bits
	typedef struct packed {
		logic [8:0] x;
		logic [7:0] y;
		logic [8:0] w;
		logic [7:0] h;
	} rect_t;

endpackage

### hw/rtl/tbr_if.sv
// ----------------------------------------------------------------------------
// tbr_if: touch button repeat channel interfaces
// Poll input channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface tbr_in_if;
	logic        valid;
	logic        ready;
	logic        touched;
	logic [11:0] raw_x;
	logic [11:0] raw_y;
	logic [31:0] now_ms;

	modport source (output valid, touched, raw_x, raw_y, now_ms, input ready);
	modport sink   (input valid, touched, raw_x, raw_y, now_ms, output ready);
endinterface

interface tbr_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [3:0] pressed_mask;

	modport source (output valid, event_res, pressed_mask, input ready);
	modport sink   (input valid, event_res, pressed_mask, output ready);
endinterface

interface tbr_cfg_if;
	import tbr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/touch_button_repeat.sv
// ----------------------------------------------------------------------------
// touch_button_repeat: touch panel button classifier with auto-repeat
// Scales each poll to screen pixels, hit-tests four configurable buttons
// and re-emits plus/minus while held, on a programmable repeat schedule.
// ----------------------------------------------------------------------------
//
//  channel  | dir | word
//  ---------+-----+---------------------------------------------------
//  in_ch    | in  | touched, raw_x, raw_y, now_ms (one panel poll)
//  out_ch   | out | event_res, pressed_mask (one result per poll)
//  cfg      | in  | index, data (register write, always ready)
//
// One word per cycle in and out, sustained while out_ch is ready. From the
// accepting edge to out_ch.valid the word passes the input register, which
// loads at that edge, then the scaled-coordinate register, then the result
// register. The stage-1 multiply by the calibration reciprocal sets the path.
// arst_n clears all valid flags, hold state and config registers to reset values.
// Each stage moves when the one behind it is empty or moving, so a stalled
// result leaves the earlier stages free to fill.
// ----------------------------------------------------------------------------
module touch_button_repeat (
	input  logic      clk,
	input  logic      arst_n,
	tbr_in_if.sink    in_ch,
	tbr_out_if.source out_ch,
	tbr_cfg_if.sink   cfg
);
	import tbr_pkg::*;

	// ---------------- configuration registers ----------------
	logic [8:0]  strip_x_q;
	rect_t       rect_q [4];
	logic [15:0] delay_q;
	logic [15:0] rate_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_x_q <= STRIP_X_RST;
			for (int i = 0; i < 4; i++) rect_q[i] <= '0;
			delay_q   <= DELAY_RST;
			rate_q    <= RATE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_STRIP_X:    strip_x_q <= cfg.data[8:0];
				REG_PLUS_RECT:  rect_q[0] <= cfg.data;
				REG_MINUS_RECT: rect_q[1] <= cfg.data;
				REG_OK_RECT:    rect_q[2] <= cfg.data;
				REG_BACK_RECT:  rect_q[3] <= cfg.data;
				REG_DELAY:      delay_q   <= cfg.data[15:0];
				REG_RATE:       rate_q    <= cfg.data[15:0];
				default:        ; // unused index, write dropped
			endcase
		end
	end

	// ---------------- handshake ----------------
	logic vld_s1, vld_s2, out_vld_q;
	logic out_free, rdy_s2, fire2, in_acc;

	assign out_free    = !out_vld_q || out_ch.ready;
	assign fire2       = vld_s2 && out_free;
	assign rdy_s2      = !vld_s2 || out_free;
	assign in_ch.ready = !vld_s1 || rdy_s2;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ch.ready) vld_s1    <= in_ch.valid;
			if (rdy_s2)      vld_s2    <= vld_s1;
			if (out_free)    out_vld_q <= vld_s2;
		end
	end

	// ---------------- stage 1: input register ----------------
	logic        touched_s1;
	logic [11:0] raw_x_s1, raw_y_s1;
	logic [31:0] now_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			touched_s1 <= in_ch.touched;
			raw_x_s1   <= in_ch.raw_x;
			raw_y_s1   <= in_ch.raw_y;
			now_s1     <= in_ch.now_ms;
		end
	end

	// Clamp to the calibration window, then scale by the reciprocal.
	logic [11:0] cx, cy, ax, ay;
	logic [45:0] px, py;

	always_comb begin
		cx = raw_x_s1;
		if (raw_x_s1 < RAW_X_LO) cx = RAW_X_LO;
		if (raw_x_s1 > RAW_X_HI) cx = RAW_X_HI;
		cy = raw_y_s1;
		if (raw_y_s1 < RAW_Y_LO) cy = RAW_Y_LO;
		if (raw_y_s1 > RAW_Y_HI) cy = RAW_Y_HI;
		ax = cx - RAW_X_LO;
		ay = cy - RAW_Y_LO;
		px = {34'd0, ax} * {12'd0, X_RECIP};
		py = {34'd0, ay} * {12'd0, Y_RECIP};
	end

	// ---------------- stage 2: screen coordinates ----------------
	logic        touched_s2;
	logic [8:0]  x_s2;
	logic [7:0]  y_s2;
	logic [31:0] now_s2;

	always_ff @(posedge clk) begin
		if (vld_s1 && rdy_s2) begin
			touched_s2 <= touched_s1;
			x_s2       <= px[SCALE_SH+8:SCALE_SH];
			y_s2       <= py[SCALE_SH+7:SCALE_SH];
			now_s2     <= now_s1;
		end
	end

	// Hit test: edges use widened sums so a rectangle never wraps.
	logic [3:0] hit;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hit[i] = (x_s2 >= rect_q[i].x)
				&& ({1'b0, x_s2} < ({1'b0, rect_q[i].x} + {1'b0, rect_q[i].w}))
				&& (y_s2 >= rect_q[i].y)
				&& ({1'b0, y_s2} < ({1'b0, rect_q[i].y} + {1'b0, rect_q[i].h}));
		end
	end

	// ---------------- hold state and result ----------------
	logic        is_down_q;
	logic [2:0]  held_q;
	logic [31:0] deadline_q;
	logic [3:0]  mask_q;
	logic [2:0]  ev_q;

	logic [2:0]  press_ev, nxt_held, nxt_ev;
	logic [3:0]  press_mask, nxt_mask;
	logic [31:0] nxt_deadline, since_dl;
	logic        nxt_down, repeat_due;

	always_comb begin
		press_ev   = EV_NONE;
		press_mask = 4'd0;
		priority if (x_s2 < strip_x_q) begin
			press_ev = EV_OK;     // tap left of the strip, no highlight
		end else if (hit[0]) begin
			press_ev   = EV_PLUS;
			press_mask = 4'b0001;
		end else if (hit[1]) begin
			press_ev   = EV_MINUS;
			press_mask = 4'b0010;
		end else if (hit[2]) begin
			press_ev   = EV_OK;
			press_mask = 4'b0100;
		end else if (hit[3]) begin
			press_ev   = EV_BACK;
			press_mask = 4'b1000;
		end else begin
			press_ev = EV_NONE;
		end

		// wrap-safe: deadline reached when now - deadline is not negative
		since_dl   = now_s2 - deadline_q;
		repeat_due = ((held_q == EV_PLUS) || (held_q == EV_MINUS)) && !since_dl[31];

		nxt_down     = is_down_q;
		nxt_held     = held_q;
		nxt_mask     = mask_q;
		nxt_deadline = deadline_q;
		nxt_ev       = EV_NONE;
		priority if (!touched_s2) begin
			nxt_down = 1'b0;
			nxt_held = EV_NONE;
			nxt_mask = 4'd0;
		end else if (!is_down_q) begin
			nxt_down     = 1'b1;
			nxt_held     = press_ev;
			nxt_mask     = press_mask;
			nxt_deadline = now_s2 + {16'd0, delay_q};
			nxt_ev       = press_ev;
		end else if (repeat_due) begin
			nxt_deadline = now_s2 + {16'd0, rate_q};
			nxt_ev       = held_q;
		end else begin
			nxt_ev = EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_down_q  <= 1'b0;
			held_q     <= EV_NONE;
			deadline_q <= '0;
			mask_q     <= '0;
		end else if (fire2) begin
			is_down_q  <= nxt_down;
			held_q     <= nxt_held;
			deadline_q <= nxt_deadline;
			mask_q     <= nxt_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (fire2) ev_q <= nxt_ev;
	end

	// mask_q only changes when a new result is loaded, so it is the result mask
	assign out_ch.valid        = out_vld_q;
	assign out_ch.event_res    = ev_q;
	assign out_ch.pressed_mask = mask_q;

	// ---------------- assertions ----------------
	a_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(mask_q))
		else $error("more than one button highlighted");

	a_mask_needs_down: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_q != 4'd0) |-> is_down_q)
		else $error("highlight without a held press");

	a_held_needs_down: assert property (@(posedge clk) disable iff (!arst_n)
		!is_down_q |-> (held_q == EV_NONE))
		else $error("held event kept after release");

	a_release_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire2 && !touched_s2) |=> (out_vld_q && ev_q == EV_NONE && mask_q == 4'd0))
		else $error("release did not give an empty result");

	a_repeat_only_pm: assert property (@(posedge clk) disable iff (!arst_n)
		(fire2 && touched_s2 && is_down_q && nxt_ev != EV_NONE)
		|-> (held_q == EV_PLUS || held_q == EV_MINUS))
		else $error("repeat on a button that does not repeat");

endmodule
